// ===== hdl/binary_max_heap_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the heap queue. They assume a clock named clk and an
// active-low reset named rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_pkg
// Types, constants and index helpers shared by the heap queue files.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = 7;
    localparam int CHILD_W = ADDR_W + 2;
    localparam int DATA_W  = 16;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic        [DATA_W-1:0] payload;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_POP_LOAD,
        ST_DOWN_CMP,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] parent_idx(input logic [ADDR_W-1:0] i);
        return ADDR_W'(i - ADDR_W'(1)) >> 1;
    endfunction

    // Full-width child indices, so that a child past the last slot compares correctly.
    function automatic logic [CHILD_W-1:0] left_idx(input logic [ADDR_W-1:0] i);
        return CHILD_W'({i, 1'b1});
    endfunction

    function automatic logic [CHILD_W-1:0] right_idx(input logic [ADDR_W-1:0] i);
        return CHILD_W'({i, 1'b1}) + CHILD_W'(1);
    endfunction

endpackage

// ===== hdl/bmhq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_if
// Request and response channel interfaces of the heap queue.
// ----------------------------------------------------------------------------
interface bmhq_req_if
    import bmhq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic        [DATA_W-1:0] payload;
    logic signed [DATA_W-1:0] priority_req;

    modport source (output valid, op, payload, priority_req, input ready);
    modport sink   (input valid, op, payload, priority_req, output ready);
endinterface

interface bmhq_rsp_if
    import bmhq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [DATA_W-1:0] top_payload;
    logic signed [DATA_W-1:0] top_priority;
    logic                     is_empty;
    logic        [CNT_W-1:0]  entry_count;
    logic        [1:0]        status;

    modport source (output valid, top_payload, top_priority, is_empty, entry_count, status,
                    input ready);
    modport sink   (input valid, top_payload, top_priority, is_empty, entry_count, status,
                    output ready);
endinterface

// ===== hdl/binary_max_heap_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Binary max-heap priority queue of 64 entries held in a block memory.
// ----------------------------------------------------------------------------
// Usage: each request word is a push (payload and signed priority) or a pop.
// Every request yields exactly one response word giving the top entry, the
// empty flag, the entry count and a status (ok, push dropped when full, pop
// on empty). A larger priority is served first; equal priorities keep no
// arrival order.
// Operation: the heap lives in a memory with one write port and two registered
// read ports. A push climbs one level per compare step and a pop moves the
// last entry to the root and sifts it down one level per step. A push into an
// empty heap, a pop that empties it and a dropped request go straight to the
// response. One request is worked at a time.
// The next request is taken as soon as the previous result is registered, so
// a stalled receiver holds the response but not the request side, until a
// second result is ready to be registered.
// Reset empties the queue at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_top_assert.svh"

module binary_max_heap_queue_top
    import bmhq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bmhq_req_if.sink   req,
    bmhq_rsp_if.source rsp
);

    entry_t mem [DEPTH];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    entry_t             cur_reg, cur_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [1:0]         stat_reg, stat_next;
    entry_t             root_reg;
    entry_t             rd0, rd1;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    entry_t             wdata;
    logic [ADDR_W-1:0]  raddr0, raddr1;
    logic               req_ready;
    logic               load_out;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_payload_reg;
    logic [DATA_W-1:0]  out_prio_reg;
    logic               out_empty_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic [1:0]         out_status_reg;

    logic [CHILD_W-1:0] left_w, right_w;
    logic               has_left, has_right, take_left;
    logic [ADDR_W-1:0]  child;
    entry_t             new_entry;

    assign new_entry = '{prio: req.priority_req, payload: req.payload};
    assign left_w    = left_idx(idx_reg);
    assign right_w   = right_idx(idx_reg);
    assign has_left  = left_w  < CHILD_W'(count_reg);
    assign has_right = right_w < CHILD_W'(count_reg);
    assign take_left = !has_right || (rd0.prio > rd1.prio);
    assign child     = take_left ? left_w[ADDR_W-1:0] : right_w[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        idx_reg  <= idx_next;
        stat_reg <= stat_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        stat_next  = stat_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = cur_reg;
        raddr0     = '0;
        raddr1     = '0;
        req_ready  = 1'b0;
        load_out   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    stat_next = STATUS_OK;
                    unique case (req.op)
                        OP_PUSH:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                stat_next  = STATUS_FULL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cur_next   = new_entry;
                                idx_next   = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                                raddr0     = parent_idx(count_reg[ADDR_W-1:0]);
                                if (count_reg == '0)
                                begin
                                    we         = 1'b1;
                                    waddr      = '0;
                                    wdata      = new_entry;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    state_next = ST_UP_CMP;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next  = STATUS_EMPTY;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                raddr0     = ADDR_W'(count_reg - CNT_W'(1));
                                state_next = (count_reg == CNT_W'(1)) ? ST_DONE : ST_POP_LOAD;
                            end
                        end
                    endcase
                end
            end

            ST_UP_CMP:
            begin
                // rd0 holds the parent of the hole at idx_reg.
                if (idx_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = ST_DONE;
                end
                else if (cur_reg.prio > rd0.prio)
                begin
                    we       = 1'b1;
                    wdata    = rd0;
                    idx_next = parent_idx(idx_reg);
                    raddr0   = parent_idx(parent_idx(idx_reg));
                end
                else
                begin
                    we         = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_POP_LOAD:
            begin
                // The last entry becomes the sifting entry; the hole is the root.
                cur_next   = rd0;
                idx_next   = '0;
                raddr0     = ADDR_W'(left_idx(ADDR_W'(0)));
                raddr1     = ADDR_W'(right_idx(ADDR_W'(0)));
                state_next = ST_DOWN_CMP;
            end

            ST_DOWN_CMP:
            begin
                if (has_left && ((cur_reg.prio < rd0.prio) ||
                                 (has_right && (cur_reg.prio < rd1.prio))))
                begin
                    we       = 1'b1;
                    wdata    = take_left ? rd0 : rd1;
                    idx_next = child;
                    raddr0   = ADDR_W'(left_idx(child));
                    raddr1   = ADDR_W'(right_idx(child));
                end
                else
                begin
                    we         = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0 <= mem[raddr0];
        rd1 <= mem[raddr1];
    end

    // Shadow of the root slot so the response needs no extra memory read.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == '0))
        begin
            root_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_payload_reg <= (count_reg == '0) ? '0 : root_reg.payload;
            out_prio_reg    <= (count_reg == '0) ? '0 : root_reg.prio;
            out_empty_reg   <= (count_reg == '0);
            out_count_reg   <= count_reg;
            out_status_reg  <= stat_reg;
        end
    end

    assign req.ready        = req_ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.top_payload  = out_payload_reg;
    assign rsp.top_priority = out_prio_reg;
    assign rsp.is_empty     = out_empty_reg;
    assign rsp.entry_count  = out_count_reg;
    assign rsp.status       = out_status_reg;

    `BMHQ_ASSERT_SAME(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH),
        "entry count exceeds the heap depth")
    `BMHQ_ASSERT_SAME(a_sift_write_in_range, we && (state_reg != ST_IDLE),
        CNT_W'(waddr) < count_reg, "sift writes beyond the held entries")
    `BMHQ_ASSERT_SAME(a_busy_not_empty,
        (state_reg == ST_UP_CMP) || (state_reg == ST_POP_LOAD) || (state_reg == ST_DOWN_CMP),
        count_reg != '0, "sift in progress on an empty heap")
    `BMHQ_ASSERT_NEXT(a_full_push_drops,
        req.valid && req_ready && (req.op == OP_PUSH) && (count_reg == CNT_W'(DEPTH)),
        (count_reg == CNT_W'(DEPTH)) && (stat_reg == STATUS_FULL),
        "push to a full heap changed the count")
    `BMHQ_ASSERT_SAME(a_idle_write_only_on_accept, we && (state_reg == ST_IDLE),
        req.valid && (count_reg == '0), "memory written while idle without a push")

endmodule

// ===== test/binary_max_heap_queue_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top_test
// Self-checking bench for the heap queue. A queue of push and pop words is
// sent through the request channel with random gaps. A behavioral heap in
// the bench predicts the response of every accepted word, and each response
// is checked field by field against it while the response side stalls at
// random. The run covers a directed opening, then phases that fill the heap
// to its limit, drain it past empty and mix both.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top_test;
    import bmhq_pkg::*;

    localparam int IDLE_PCT     = 13;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 106;
    localparam int PHASE_COUNT  = 8;

    typedef struct packed {
        logic                     op;
        logic        [DATA_W-1:0] payload;
        logic signed [DATA_W-1:0] prio;
    } heap_word_t;

    typedef struct packed {
        logic        [DATA_W-1:0] top_payload;
        logic signed [DATA_W-1:0] top_priority;
        logic                     is_empty;
        logic        [CNT_W-1:0]  entry_count;
        logic        [1:0]        status;
    } heap_view_t;

    logic clk;
    logic rst_n;

    bmhq_req_if req_ch ();
    bmhq_rsp_if rsp_ch ();

    binary_max_heap_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    heap_word_t words_to_send[$];
    heap_view_t predicted_views[$];
    entry_t     heap_slots[DEPTH];
    int         heap_size;
    int         sent_count;
    int         seen_count;
    int         mismatch_count;
    int         quiet_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Applies one word to the bench heap and returns the view it leaves.
    function automatic heap_view_t apply_heap_word(input heap_word_t w);
        heap_view_t view;
        entry_t     tmp;
        int         idx;
        int         parent;
        int         lft;
        int         rgt;
        int         pick;
        bit         settled;

        view.status = STATUS_OK;
        if (w.op == OP_PUSH)
        begin
            if (heap_size >= DEPTH)
                view.status = STATUS_FULL;
            else
            begin
                heap_slots[heap_size] = '{prio: w.prio, payload: w.payload};
                idx = heap_size;
                heap_size++;
                settled = 1'b0;
                while (idx > 0 && !settled)
                begin
                    parent = (idx - 1) / 2;
                    if ($signed(heap_slots[idx].prio) > $signed(heap_slots[parent].prio))
                    begin
                        tmp = heap_slots[idx];
                        heap_slots[idx] = heap_slots[parent];
                        heap_slots[parent] = tmp;
                        idx = parent;
                    end
                    else
                        settled = 1'b1;
                end
            end
        end
        else
        begin
            if (heap_size == 0)
                view.status = STATUS_EMPTY;
            else
            begin
                heap_slots[0] = heap_slots[heap_size - 1];
                heap_size--;
                idx = 0;
                settled = 1'b0;
                while (!settled)
                begin
                    lft = 2 * idx + 1;
                    rgt = 2 * idx + 2;
                    if (lft >= heap_size)
                        settled = 1'b1;
                    else
                    begin
                        // The right child wins a tie between the two children.
                        pick = lft;
                        if (rgt < heap_size &&
                            !($signed(heap_slots[lft].prio) > $signed(heap_slots[rgt].prio)))
                            pick = rgt;
                        if ($signed(heap_slots[idx].prio) < $signed(heap_slots[pick].prio))
                        begin
                            tmp = heap_slots[idx];
                            heap_slots[idx] = heap_slots[pick];
                            heap_slots[pick] = tmp;
                            idx = pick;
                        end
                        else
                            settled = 1'b1;
                    end
                end
            end
        end

        if (heap_size == 0)
        begin
            view.top_payload  = '0;
            view.top_priority = '0;
            view.is_empty     = 1'b1;
        end
        else
        begin
            view.top_payload  = heap_slots[0].payload;
            view.top_priority = heap_slots[0].prio;
            view.is_empty     = 1'b0;
        end
        view.entry_count = CNT_W'(heap_size);
        return view;
    endfunction

    task automatic add_word(input logic op, input logic [DATA_W-1:0] payload,
                            input logic signed [DATA_W-1:0] prio);
        words_to_send.push_back('{op: op, payload: payload, prio: prio});
    endtask

    // Small priorities make ties common; extremes hit the signed corners.
    task automatic add_random_word(input int push_pct);
        logic signed [DATA_W-1:0] prio;
        int                       pick;

        pick = $urandom_range(99);
        if (pick < 25)
            prio = DATA_W'($signed($urandom_range(6)) - 3);
        else if (pick < 35)
        begin
            case ($urandom_range(3))
                0:       prio = 16'sh8000;
                1:       prio = 16'sh7fff;
                2:       prio = -16'sd1;
                default: prio = 16'sd0;
            endcase
        end
        else
            prio = DATA_W'($urandom);
        add_word(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP, DATA_W'($urandom), prio);
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || req_ch.valid || predicted_views.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Request driver: a new word goes out once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted_views.push_back(apply_heap_word(
                    '{op: req_ch.op, payload: req_ch.payload, prio: req_ch.priority_req}));
                sent_count++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (words_to_send.size() != 0 &&
                    ((sent_count >= 400 && sent_count < 520) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    heap_word_t w;
                    w = words_to_send.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.op           <= w.op;
                    req_ch.payload      <= w.payload;
                    req_ch.priority_req <= w.prio;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor and random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_count++;
                if (predicted_views.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: response word with no request outstanding", $time);
                end
                else
                begin
                    heap_view_t want;
                    want = predicted_views.pop_front();
                    check_field("top_payload", want.top_payload, rsp_ch.top_payload);
                    check_field("top_priority", want.top_priority, rsp_ch.top_priority);
                    check_field("is_empty", want.is_empty, rsp_ch.is_empty);
                    check_field("entry_count", want.entry_count, rsp_ch.entry_count);
                    check_field("status", want.status, rsp_ch.status);
                end
            end
            rsp_ch.ready <= ((seen_count >= 400 && seen_count < 520) ||
                             $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int push_pct;

        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_PUSH;
        req_ch.payload      = '0;
        req_ch.priority_req = '0;
        rsp_ch.ready        = 1'b0;
        sent_count          = 0;
        seen_count          = 0;
        mismatch_count      = 0;
        quiet_cycles        = 0;
        heap_size           = 0;

        // Pop on an empty heap, signed and payload extremes, equal priorities.
        add_word(OP_POP,  16'h0000, 16'sd0);
        add_word(OP_PUSH, 16'h0000, 16'sh8000);
        add_word(OP_PUSH, 16'hffff, 16'sh7fff);
        add_word(OP_PUSH, 16'h1234, 16'sd0);
        add_word(OP_PUSH, 16'haaaa, -16'sd1);
        add_word(OP_PUSH, 16'h5555, 16'sh7fff);
        add_word(OP_PUSH, 16'h8001, 16'sh7fff);
        add_word(OP_PUSH, 16'h7ffe, 16'sd1);
        repeat (8)
            add_word(OP_POP, 16'hffff, 16'sh7fff);
        add_word(OP_PUSH, 16'h0a0a, 16'sd5);
        add_word(OP_PUSH, 16'h0b0b, 16'sd5);
        add_word(OP_PUSH, 16'h0c0c, 16'sd5);
        add_word(OP_PUSH, 16'h0d0d, 16'sd5);
        add_word(OP_POP,  16'h0000, 16'sd0);
        add_word(OP_POP,  16'h0000, 16'sd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait_until_drained();

        // Alternate filling and draining phases so the heap hits full and empty.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase % 3)
                0:       push_pct = 88;
                1:       push_pct = 15;
                default: push_pct = 55;
            endcase
            repeat (PHASE_WORDS)
                add_random_word(push_pct);
            if (phase == 2 || phase == 5)
                wait_until_drained();
        end

        wait_until_drained();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== binary_max_heap_queue_top.f =====
+incdir+hdl
hdl/bmhq_pkg.sv
hdl/bmhq_if.sv
hdl/binary_max_heap_queue_top.sv
test/binary_max_heap_queue_top_test.sv
